[design/ps2_keyboard_controller_top_macros.svh]
// assertion helpers for the keyboard controller
`ifndef PS2_KEYBOARD_CONTROLLER_TOP_MACROS_SVH
`define PS2_KEYBOARD_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication under reset
`define KBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kbc assertion failed");

// next-cycle implication under reset
`define KBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kbc assertion failed");

`else

`define KBC_ASSERT_NOW(lbl, ante, cons)
`define KBC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[design/kbc_pkg.sv]
`timescale 1ns / 1ps

package kbc_pkg;

  // output stack geometry
  localparam int BUFFER_DEPTH = 16;
  localparam int CNT_W = $clog2(BUFFER_DEPTH);

  // classified operation
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_DATA_WR = 3'd1,
    OP_CMD_WR  = 3'd2,
    OP_DATA_RD = 3'd3,
    OP_STAT_RD = 3'd4,
    OP_KEY     = 3'd5
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic [15:0] code;
    logic        rel;
  } item_t;

  // func codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_KEY   = 2'd2;

  // reply bytes
  localparam logic [7:0] BYTE_ACK       = 8'hFA;
  localparam logic [7:0] BYTE_BAT_OK    = 8'hAA;
  localparam logic [7:0] BYTE_TEST_OK   = 8'h55;
  localparam logic [7:0] BYTE_ID0       = 8'h83;
  localparam logic [7:0] BYTE_ID1       = 8'hAB;
  localparam logic [7:0] BYTE_BREAK     = 8'hF0;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] SCAN_SET_TWO   = 8'h02;

  // keyboard commands
  localparam logic [7:0] KBD_RESET     = 8'hFF;
  localparam logic [7:0] KBD_DISABLE   = 8'hF5;
  localparam logic [7:0] KBD_ENABLE    = 8'hF4;
  localparam logic [7:0] KBD_TYPEMATIC = 8'hF3;
  localparam logic [7:0] KBD_SCAN_SET  = 8'hF0;
  localparam logic [7:0] KBD_LEDS      = 8'hED;
  localparam logic [7:0] KBD_IDENTIFY  = 8'hF2;

  // controller commands
  localparam logic [7:0] CTRL_AUX_ECHO  = 8'hD3;
  localparam logic [7:0] CTRL_DIS_AUX   = 8'hA7;
  localparam logic [7:0] CTRL_EN_AUX    = 8'hA8;
  localparam logic [7:0] CTRL_SELF_TEST = 8'hAA;
  localparam logic [7:0] CTRL_TEST_KBD  = 8'hAB;
  localparam logic [7:0] CTRL_TEST_AUX  = 8'hA9;
  localparam logic [7:0] CTRL_DIS_KBD   = 8'hAD;
  localparam logic [7:0] CTRL_EN_KBD    = 8'hAE;

  // port flag bit positions
  localparam int PF_A_EN  = 0;
  localparam int PF_B_EN  = 1;
  localparam int PF_A_IRQ = 2;
  localparam int PF_B_IRQ = 3;
  localparam int PF_A_CLK = 4;
  localparam int PF_B_CLK = 5;
  localparam int PF_XLAT  = 6;
  localparam int PF_SCAN  = 7;

  localparam logic [7:0] SET1_LOW [128] = '{
    8'hff, 8'h43, 8'h41, 8'h3f, 8'h3d, 8'h3b, 8'h3c, 8'h58,
    8'h64, 8'h44, 8'h42, 8'h40, 8'h3e, 8'h0f, 8'h29, 8'h59,
    8'h65, 8'h38, 8'h2a, 8'h70, 8'h1d, 8'h10, 8'h02, 8'h5a,
    8'h66, 8'h71, 8'h2c, 8'h1f, 8'h1e, 8'h11, 8'h03, 8'h5b,
    8'h67, 8'h2e, 8'h2d, 8'h20, 8'h12, 8'h05, 8'h04, 8'h5c,
    8'h68, 8'h39, 8'h2f, 8'h21, 8'h14, 8'h13, 8'h06, 8'h5d,
    8'h69, 8'h31, 8'h30, 8'h23, 8'h22, 8'h15, 8'h07, 8'h5e,
    8'h6a, 8'h72, 8'h32, 8'h24, 8'h16, 8'h08, 8'h09, 8'h5f,
    8'h6b, 8'h33, 8'h25, 8'h17, 8'h18, 8'h0b, 8'h0a, 8'h60,
    8'h6c, 8'h34, 8'h35, 8'h26, 8'h27, 8'h19, 8'h0c, 8'h61,
    8'h6d, 8'h73, 8'h28, 8'h74, 8'h1a, 8'h0d, 8'h62, 8'h6e,
    8'h3a, 8'h36, 8'h1c, 8'h1b, 8'h75, 8'h2b, 8'h63, 8'h76,
    8'h55, 8'h56, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h0e, 8'h7b,
    8'h7c, 8'h4f, 8'h7d, 8'h4b, 8'h47, 8'h7e, 8'h7f, 8'h6f,
    8'h52, 8'h53, 8'h50, 8'h4c, 8'h4d, 8'h48, 8'h01, 8'h45,
    8'h57, 8'h4e, 8'h51, 8'h4a, 8'h37, 8'h49, 8'h46, 8'h54
  };

  // set 2 to set 1 translation
  function automatic logic [7:0] xlat(input logic [7:0] c);
    logic [7:0] r;
    if (!c[7]) r = SET1_LOW[c[6:0]];
    else if (c == 8'h83) r = 8'h41;
    else if (c == 8'h84) r = 8'h54;
    else r = c;
    return r;
  endfunction

endpackage

[design/kbc_front.sv]
`timescale 1ns / 1ps

module kbc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic                port_sel_i,
  input  logic [7:0]          write_data_i,
  input  logic [15:0]         key_scancode_i,
  input  logic                key_release_i,
  output logic                head_valid_o,
  output kbc_pkg::item_t      head_o,
  input  logic                head_pop_i
);

  kbc_pkg::item_t item;
  kbc_pkg::item_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  // classify the incoming transaction
  always_comb begin
    item.data = write_data_i;
    item.code = key_scancode_i;
    item.rel  = key_release_i;
    case (func_i)
      kbc_pkg::FUNC_WRITE: item.op = port_sel_i ? kbc_pkg::OP_CMD_WR : kbc_pkg::OP_DATA_WR;
      kbc_pkg::FUNC_READ:  item.op = port_sel_i ? kbc_pkg::OP_STAT_RD : kbc_pkg::OP_DATA_RD;
      kbc_pkg::FUNC_KEY:   item.op = kbc_pkg::OP_KEY;
      default:             item.op = kbc_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = head_pop_i && head_valid_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  // two-entry queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= item;
  end

endmodule

[design/kbc_back.sv]
`timescale 1ns / 1ps

module kbc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  kbc_pkg::item_t head_i,
  output logic           head_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     read_data_o,
  output logic           irq_pulse_o,
  output logic           fault_o
);

  localparam logic [kbc_pkg::CNT_W-1:0] CNT_LAST =
    kbc_pkg::CNT_W'(kbc_pkg::BUFFER_DEPTH - 1);

  logic [7:0] stack_q [kbc_pkg::BUFFER_DEPTH];
  logic [7:0] stack_d [kbc_pkg::BUFFER_DEPTH];
  logic [kbc_pkg::CNT_W-1:0] cnt_q, cnt_d, idx, cnt_m1;
  logic       obf_q, obf_d;
  logic [7:0] ram_q [32];
  logic       ram_we;
  logic [4:0] ram_wa;
  logic [7:0] pc_q, pc_d, pk_q, pk_d, scan_q, scan_d, flags_q, flags_d;
  logic [7:0] push_b [3];
  logic       push_v [3];
  logic [7:0] cand_b [3];
  logic       cand_v [3];
  logic       brk, any_push, fire, flt;
  logic [7:0] rd, wd;
  logic       out_valid_q;
  logic [7:0] rd_q;
  logic       irq_q, flt_q;

  assign fire        = head_valid_i && (!out_valid_q || out_ready_i);
  assign head_pop_o  = fire;
  assign wd          = head_i.data;
  assign cnt_m1      = cnt_q - 1'b1;

  // execute the head transaction
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      push_b[k] = '0;
      push_v[k] = 1'b0;
      cand_b[k] = '0;
      cand_v[k] = 1'b0;
    end
    brk     = 1'b0;
    flags_d = flags_q;
    scan_d  = scan_q;
    pc_d    = pc_q;
    pk_d    = pk_q;
    ram_we  = 1'b0;
    ram_wa  = pc_q[4:0];
    rd      = '0;
    flt     = 1'b0;
    case (head_i.op)
      kbc_pkg::OP_DATA_WR: begin
        if (pc_q != 8'h00) begin
          if (pc_q inside {[8'h60:8'h7F]}) begin
            ram_we = 1'b1;
            if (pc_q[4:0] == 5'd0) begin
              flags_d = flags_q & ((8'h1 << kbc_pkg::PF_A_EN) | (8'h1 << kbc_pkg::PF_B_EN)
                                   | (8'h1 << kbc_pkg::PF_SCAN));
              flags_d[kbc_pkg::PF_A_IRQ] = wd[0];
              flags_d[kbc_pkg::PF_B_IRQ] = wd[1];
              flags_d[kbc_pkg::PF_A_CLK] = !wd[4];
              flags_d[kbc_pkg::PF_B_CLK] = !wd[5];
              flags_d[kbc_pkg::PF_XLAT]  = wd[6];
            end
          end else if (pc_q == kbc_pkg::CTRL_AUX_ECHO) begin
            push_b[0] = wd;
            push_v[0] = 1'b1;
          end
          pc_d = 8'h00;
        end else if (pk_q != 8'h00) begin
          if (pk_q == kbc_pkg::KBD_SCAN_SET && wd == 8'h00) begin
            push_b[0] = flags_q[kbc_pkg::PF_XLAT] ? kbc_pkg::xlat(scan_q) : scan_q;
            push_v[0] = 1'b1;
          end else if (pk_q == kbc_pkg::KBD_SCAN_SET) begin
            scan_d = wd;
          end
          push_b[1] = kbc_pkg::BYTE_ACK;
          push_v[1] = 1'b1;
          pk_d = 8'h00;
        end else begin
          push_b[2] = kbc_pkg::BYTE_ACK;
          push_v[2] = 1'b1;
          case (wd)
            kbc_pkg::KBD_RESET: begin
              push_b[1] = kbc_pkg::BYTE_BAT_OK;
              push_v[1] = 1'b1;
            end
            kbc_pkg::KBD_DISABLE: flags_d[kbc_pkg::PF_SCAN] = 1'b0;
            kbc_pkg::KBD_ENABLE:  flags_d[kbc_pkg::PF_SCAN] = 1'b1;
            kbc_pkg::KBD_TYPEMATIC, kbc_pkg::KBD_SCAN_SET, kbc_pkg::KBD_LEDS: pk_d = wd;
            kbc_pkg::KBD_IDENTIFY: begin
              push_b[0] = kbc_pkg::BYTE_ID0;
              push_v[0] = 1'b1;
              push_b[1] = kbc_pkg::BYTE_ID1;
              push_v[1] = 1'b1;
            end
            default: begin
              push_v[2] = 1'b0;
              flt = 1'b1;
            end
          endcase
        end
      end
      kbc_pkg::OP_CMD_WR: begin
        if (wd inside {[8'h20:8'h3F]}) begin
          push_b[0] = ram_q[wd[4:0]];
          push_v[0] = 1'b1;
        end else if (wd inside {[8'h60:8'h7F], kbc_pkg::CTRL_AUX_ECHO}) begin
          pc_d = wd;
        end else begin
          case (wd)
            kbc_pkg::CTRL_DIS_AUX: flags_d[kbc_pkg::PF_B_EN] = 1'b0;
            kbc_pkg::CTRL_EN_AUX:  flags_d[kbc_pkg::PF_B_EN] = 1'b1;
            kbc_pkg::CTRL_DIS_KBD: flags_d[kbc_pkg::PF_A_EN] = 1'b0;
            kbc_pkg::CTRL_EN_KBD:  flags_d[kbc_pkg::PF_A_EN] = 1'b1;
            kbc_pkg::CTRL_SELF_TEST: begin
              push_b[0] = kbc_pkg::BYTE_TEST_OK;
              push_v[0] = 1'b1;
            end
            kbc_pkg::CTRL_TEST_KBD, kbc_pkg::CTRL_TEST_AUX: begin
              push_b[0] = kbc_pkg::BYTE_ZERO;
              push_v[0] = 1'b1;
            end
            default: flt = 1'b1;
          endcase
        end
      end
      kbc_pkg::OP_DATA_RD: begin
        if (cnt_q != '0) rd = stack_q[cnt_m1];
      end
      kbc_pkg::OP_STAT_RD: begin
        rd = {7'd0, obf_q};
      end
      kbc_pkg::OP_KEY: begin
        if (scan_q == kbc_pkg::SCAN_SET_TWO && head_i.code != 16'h0000) begin
          cand_b[0] = head_i.code[15:8];
          cand_v[0] = (head_i.code[15:8] != 8'h00);
          cand_b[1] = kbc_pkg::BYTE_BREAK;
          cand_v[1] = head_i.rel;
          cand_b[2] = head_i.code[7:0];
          cand_v[2] = 1'b1;
        end
        // break prefix folds into bit 7 when translating
        for (int k = 0; k < 3; k++) begin
          if (cand_v[k]) begin
            if (!flags_q[kbc_pkg::PF_XLAT]) begin
              push_b[k] = cand_b[k];
              push_v[k] = 1'b1;
            end else if (cand_b[k] == kbc_pkg::BYTE_BREAK) begin
              brk = 1'b1;
            end else begin
              push_b[k] = kbc_pkg::xlat(cand_b[k]) | {brk, 7'd0};
              push_v[k] = 1'b1;
              brk = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // stack update with wrap on overflow
  always_comb begin
    stack_d  = stack_q;
    idx      = cnt_q;
    any_push = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (push_v[k]) begin
        stack_d[idx] = push_b[k];
        idx = (idx == CNT_LAST) ? '0 : idx + 1'b1;
        any_push = 1'b1;
      end
    end
    cnt_d = idx;
    obf_d = obf_q | any_push;
    if (head_i.op == kbc_pkg::OP_DATA_RD && cnt_q != '0) begin
      cnt_d = cnt_m1;
      if (cnt_m1 == '0) obf_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      obf_q       <= 1'b0;
      pc_q        <= '0;
      pk_q        <= '0;
      scan_q      <= kbc_pkg::SCAN_SET_TWO;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 32; i++) ram_q[i] <= '0;
    end else begin
      if (fire) begin
        cnt_q   <= cnt_d;
        obf_q   <= obf_d;
        pc_q    <= pc_d;
        pk_q    <= pk_d;
        scan_q  <= scan_d;
        flags_q <= flags_d;
        if (ram_we) ram_q[ram_wa] <= wd;
      end
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // stack storage and result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      stack_q <= stack_d;
      rd_q    <= rd;
      irq_q   <= any_push && flags_q[kbc_pkg::PF_A_IRQ];
      flt_q   <= flt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rd_q;
  assign irq_pulse_o = irq_q;
  assign fault_o     = flt_q;

endmodule

[design/ps2_keyboard_controller_top.sv]
`timescale 1ns / 1ps

// 8042-style keyboard controller. Each transaction (port write, port read or
// key event) is taken into a two-entry queue and carried out by the
// execution stage, which updates the output stack, controller RAM and
// keyboard state; one result comes out per transaction, from a result
// register. Sustained rate is one transaction per clock while the receiver
// takes each result. The output stack is last-in-first-out and empties
// itself when it fills. Status reads give output-full in bit 0 and zero
// in bits 7 to 1.

`include "ps2_keyboard_controller_top_macros.svh"

module ps2_keyboard_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic        port_sel_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] key_scancode_i,
  input  logic        key_release_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        irq_pulse_o,
  output logic        fault_o
);

  kbc_pkg::item_t head;
  logic           head_valid, head_pop;

  // classify and queue
  kbc_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .port_sel_i,
    .write_data_i,
    .key_scancode_i,
    .key_release_i,
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  // execute and hold result
  kbc_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .out_valid_o,
    .out_ready_i,
    .read_data_o,
    .irq_pulse_o,
    .fault_o
  );

  // queue never backs up while the result register is empty
  `KBC_ASSERT_NOW(a_ready_when_drained, !out_valid_o, in_ready_o)
  // an ignored command pushes nothing, so no interrupt
  `KBC_ASSERT_NOW(a_fault_no_irq, out_valid_o && fault_o, !irq_pulse_o)
  // writes and key events return zero data
  `KBC_ASSERT_NOW(a_side_effect_zero, out_valid_o && (irq_pulse_o || fault_o),
                  read_data_o == 8'h00)

endmodule

[dv/kbc_reply_checker.sv]
`timescale 1ns / 1ps

module kbc_reply_checker
  import kbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic        port_sel_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] key_scancode_i,
  input  logic        key_release_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  read_data_i,
  input  logic        irq_pulse_i,
  input  logic        fault_i,
  output int          fail_count_o,
  output int          replies_owed_o
);

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
    logic       flt;
  } reply_t;

  reply_t reply_q[$];

  // predicted controller state
  logic [7:0] ostk [BUFFER_DEPTH];
  int         ocnt;
  logic       ofull;
  logic [7:0] ilat [BUFFER_DEPTH];
  int         icnt;
  logic       ifull;
  logic [7:0] ram [32];
  logic [7:0] pend_ctrl, pend_kbd, sset, pflags;
  logic       irq_hit, flt_hit, brk;

  assign replies_owed_o = reply_q.size();

  function automatic logic [7:0] to_set1(logic [7:0] c);
    if (c < 8'h80) return SET1_LOW[c[6:0]];
    if (c == 8'h83) return 8'h41;
    if (c == 8'h84) return 8'h54;
    return c;
  endfunction

  task automatic clear_state();
    ocnt = 0; ofull = 0; icnt = 0; ifull = 0;
    pend_ctrl = 0; pend_kbd = 0; sset = SCAN_SET_TWO; pflags = 0;
    for (int i = 0; i < 32; i++) ram[i] = 0;
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      ostk[i] = 0;
      ilat[i] = 0;
    end
  endtask

  // lifo push; wraps to empty when full
  task automatic out_push(logic [7:0] v);
    if (ocnt >= BUFFER_DEPTH) ocnt = 0;
    ostk[ocnt] = v;
    ocnt++;
    if (ocnt >= BUFFER_DEPTH) ocnt = 0;
    ofull = 1;
  endtask

  task automatic push_irq(logic [7:0] v);
    out_push(v);
    if (pflags[PF_A_IRQ]) irq_hit = 1;
  endtask

  task automatic in_push(logic [7:0] v);
    if (ifull || icnt >= BUFFER_DEPTH) return;
    ilat[icnt] = v;
    icnt++;
    if (icnt == BUFFER_DEPTH) ifull = 1;
  endtask

  function automatic logic [7:0] in_pop();
    if (icnt == 0) return 8'h00;
    icnt--;
    ifull = 0;
    return ilat[icnt];
  endfunction

  task automatic ctrl_cmd(logic [7:0] c);
    if (c >= 8'h20 && c <= 8'h3F) push_irq(ram[c[4:0]]);
    else if ((c >= 8'h60 && c <= 8'h7F) || c == CTRL_AUX_ECHO) pend_ctrl = c;
    else if (c == CTRL_DIS_AUX) pflags[PF_B_EN] = 0;
    else if (c == CTRL_EN_AUX) pflags[PF_B_EN] = 1;
    else if (c == CTRL_SELF_TEST) push_irq(BYTE_TEST_OK);
    else if (c == CTRL_TEST_KBD || c == CTRL_TEST_AUX) push_irq(BYTE_ZERO);
    else if (c == CTRL_DIS_KBD) pflags[PF_A_EN] = 0;
    else if (c == CTRL_EN_KBD) pflags[PF_A_EN] = 1;
    else flt_hit = 1;
  endtask

  task automatic ctrl_finish();
    logic [7:0] v, f;
    if (pend_ctrl >= 8'h60 && pend_ctrl <= 8'h7F) begin
      v = in_pop();
      ram[pend_ctrl[4:0]] = v;
      if (pend_ctrl[4:0] == 0) begin
        f = 0;
        f[PF_A_EN] = pflags[PF_A_EN];
        f[PF_B_EN] = pflags[PF_B_EN];
        f[PF_SCAN] = pflags[PF_SCAN];
        f[PF_A_IRQ] = v[0];
        f[PF_B_IRQ] = v[1];
        f[PF_A_CLK] = !v[4];
        f[PF_B_CLK] = !v[5];
        f[PF_XLAT] = v[6];
        pflags = f;
      end
    end else if (pend_ctrl == CTRL_AUX_ECHO) begin
      push_irq(in_pop());
    end
    pend_ctrl = 0;
  endtask

  task automatic kbd_cmd();
    logic [7:0] c;
    c = in_pop();
    case (c)
      KBD_RESET: begin
        out_push(BYTE_BAT_OK); push_irq(BYTE_ACK);
      end
      KBD_DISABLE: begin
        pflags[PF_SCAN] = 0; push_irq(BYTE_ACK);
      end
      KBD_ENABLE: begin
        pflags[PF_SCAN] = 1; push_irq(BYTE_ACK);
      end
      KBD_TYPEMATIC, KBD_SCAN_SET, KBD_LEDS: begin
        pend_kbd = c; push_irq(BYTE_ACK);
      end
      KBD_IDENTIFY: begin
        out_push(BYTE_ID0); out_push(BYTE_ID1); push_irq(BYTE_ACK);
      end
      default: flt_hit = 1;
    endcase
  endtask

  task automatic kbd_finish();
    logic [7:0] v;
    if (pend_kbd == KBD_TYPEMATIC || pend_kbd == KBD_LEDS) begin
      v = in_pop();
      push_irq(BYTE_ACK);
    end else if (pend_kbd == KBD_SCAN_SET) begin
      v = in_pop();
      if (v == 0) out_push(pflags[PF_XLAT] ? to_set1(sset) : sset);
      else sset = v;
      push_irq(BYTE_ACK);
    end else begin
      flt_hit = 1;
    end
    pend_kbd = 0;
  endtask

  // one scancode byte, with set 1 break folding
  task automatic emit_code(logic [7:0] c);
    if (pflags[PF_XLAT]) begin
      if (c == BYTE_BREAK) begin
        brk = 1;
        return;
      end
      out_push(to_set1(c) | (brk ? 8'h80 : 8'h00));
      brk = 0;
    end else begin
      out_push(c);
    end
    if (pflags[PF_A_IRQ]) irq_hit = 1;
  endtask

  task automatic run_transaction();
    reply_t r;
    r = '0;
    irq_hit = 0; flt_hit = 0;
    if (func_i == FUNC_WRITE) begin
      if (!port_sel_i) begin
        in_push(write_data_i);
        if (pend_ctrl != 0 && icnt == 1) ctrl_finish();
        else if (pend_kbd != 0 && icnt == 1) kbd_finish();
        else kbd_cmd();
      end else begin
        ctrl_cmd(write_data_i);
      end
    end else if (func_i == FUNC_READ) begin
      if (!port_sel_i) begin
        if (ocnt != 0) begin
          ocnt--;
          r.rd = ostk[ocnt];
          if (ocnt == 0) ofull = 0;
        end
      end else begin
        r.rd = {6'd0, ifull, ofull};
      end
    end else if (func_i == FUNC_KEY) begin
      if (sset == SCAN_SET_TWO && key_scancode_i != 0) begin
        brk = 0;
        if (key_scancode_i[15:8] != 0) emit_code(key_scancode_i[15:8]);
        if (key_release_i) emit_code(BYTE_BREAK);
        emit_code(key_scancode_i[7:0]);
      end
    end
    r.irq = irq_hit;
    r.flt = flt_hit;
    reply_q.push_back(r);
  endtask

  // predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t w;
    if (!rst_ni) begin
      clear_state();
      reply_q.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected reply rd=%h irq=%b fault=%b", $time,
                   read_data_i, irq_pulse_i, fault_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          w = reply_q.pop_front();
          if (w.rd !== read_data_i || w.irq !== irq_pulse_i || w.flt !== fault_i) begin
            $display("%0t: mismatch expected rd=%h irq=%b fault=%b, got rd=%h irq=%b fault=%b",
                     $time, w.rd, w.irq, w.flt, read_data_i, irq_pulse_i, fault_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) run_transaction();
    end
  end

endmodule

[dv/ps2_keyboard_controller_top_tb.sv]
`timescale 1ns / 1ps

module ps2_keyboard_controller_top_tb;
  import kbc_pkg::*;

  localparam int CycleLimit = 300000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_READ;
  logic        port_sel_i = 1;
  logic [7:0]  write_data_i = 0;
  logic [15:0] key_scancode_i = 0;
  logic        key_release_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [7:0]  read_data_o;
  logic        irq_pulse_o;
  logic        fault_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 0;
  int fail_count, replies_owed;

  ps2_keyboard_controller_top i_dut (.*);

  kbc_reply_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .func_i, .port_sel_i,
    .write_data_i, .key_scancode_i, .key_release_i, .out_valid_i(out_valid_o),
    .out_ready_i, .read_data_i(read_data_o), .irq_pulse_i(irq_pulse_o),
    .fault_i(fault_o), .fail_count_o(fail_count), .replies_owed_o(replies_owed)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // timeout
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one transaction: optional gap, then hold valid until accepted
  task automatic send(logic [1:0] f, logic s, logic [7:0] d, logic [15:0] c, logic r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    func_i <= f;
    port_sel_i <= s;
    write_data_i <= d;
    key_scancode_i <= c;
    key_release_i <= r;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic data_wr(logic [7:0] d);
    send(FUNC_WRITE, 1'b0, d, 16'($urandom), 1'($urandom));
  endtask

  task automatic cmd_wr(logic [7:0] d);
    send(FUNC_WRITE, 1'b1, d, 16'($urandom), 1'($urandom));
  endtask

  task automatic key(logic [15:0] c, logic r);
    send(FUNC_KEY, 1'($urandom), 8'($urandom), c, r);
  endtask

  task automatic pop_byte();
    send(FUNC_READ, 1'b0, 8'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // random scancode, mostly plain or E0-prefixed
  function automatic logic [15:0] rand_code();
    int k;
    k = $urandom_range(9);
    if (k < 5) return {8'h00, 8'($urandom)};
    if (k < 8) return {8'hE0, 8'($urandom)};
    return 16'($urandom);
  endfunction

  // mostly well-formed command sequences, some noise
  task automatic random_op();
    logic [7:0] kc, arg;
    int k;
    k = $urandom_range(99);
    if (k < 25) begin
      key(rand_code(), 1'($urandom));
    end else if (k < 45) begin
      pop_byte();
    end else if (k < 50) begin
      send(FUNC_READ, 1'b1, 8'($urandom), 16'($urandom), 1'($urandom));
    end else if (k < 65) begin
      case ($urandom_range(7))
        0: kc = KBD_RESET;
        1: kc = KBD_DISABLE;
        2: kc = KBD_ENABLE;
        3: kc = KBD_TYPEMATIC;
        4: kc = KBD_SCAN_SET;
        5: kc = KBD_LEDS;
        6: kc = KBD_IDENTIFY;
        default: kc = 8'($urandom);
      endcase
      data_wr(kc);
      if (kc == KBD_SCAN_SET) begin
        k = $urandom_range(9);
        arg = (k < 6) ? SCAN_SET_TWO : (k < 8) ? 8'h00 : 8'($urandom);
        data_wr(arg);
      end else if ((kc == KBD_TYPEMATIC || kc == KBD_LEDS) && $urandom_range(9) != 0) begin
        data_wr(8'($urandom));
      end
    end else if (k < 85) begin
      case ($urandom_range(11))
        0: kc = 8'h20 | 8'($urandom_range(31));
        1, 2: kc = 8'h60 | 8'($urandom_range(31));
        3: kc = CTRL_AUX_ECHO;
        4: kc = CTRL_DIS_AUX;
        5: kc = CTRL_EN_AUX;
        6: kc = CTRL_SELF_TEST;
        7: kc = CTRL_TEST_KBD;
        8: kc = CTRL_TEST_AUX;
        9: kc = CTRL_DIS_KBD;
        10: kc = CTRL_EN_KBD;
        default: kc = 8'($urandom);
      endcase
      // ram writes often target byte 0 so the flags move
      if (kc[7:5] == 3'b011 && $urandom_range(1) != 0) kc = 8'h60;
      cmd_wr(kc);
      if ((kc >= 8'h60 && kc <= 8'h7F) || kc == CTRL_AUX_ECHO) data_wr(8'($urandom));
    end else begin
      send(2'($urandom_range(2)), 1'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: keyboard commands and their replies
    data_wr(KBD_RESET);
    pop_byte();
    pop_byte();
    send(FUNC_READ, 1'b1, 8'h00, 16'h0000, 1'b0);
    data_wr(KBD_IDENTIFY);
    data_wr(8'h00);
    cmd_wr(CTRL_SELF_TEST);
    cmd_wr(CTRL_TEST_KBD);
    cmd_wr(CTRL_TEST_AUX);
    cmd_wr(CTRL_DIS_AUX);
    cmd_wr(CTRL_EN_AUX);
    cmd_wr(CTRL_DIS_KBD);
    cmd_wr(CTRL_EN_KBD);
    cmd_wr(8'h00);
    // irq enable and translation through ram byte 0
    cmd_wr(8'h60);
    data_wr(8'h41);
    cmd_wr(8'h20);
    key(16'hE071, 1'b1);
    key(16'hFFFF, 1'b0);
    key(16'h0000, 1'b1);
    cmd_wr(CTRL_AUX_ECHO);
    data_wr(8'hFF);
    data_wr(KBD_SCAN_SET);
    data_wr(8'h00);
    data_wr(KBD_SCAN_SET);
    data_wr(8'h03);
    key(16'h001C, 1'b0);
    data_wr(KBD_SCAN_SET);
    data_wr(SCAN_SET_TWO);
    data_wr(KBD_LEDS);
    data_wr(8'h07);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 69 : (ph == 3) ? 22 : 0;
      recv_stall_pct = (ph == 2) ? 69 : (ph == 3) ? 22 : 0;
      for (int n = 0; n < 350; n++) begin
        if (ph == 0 && n == 100) hold_req <= 1;
        random_op();
      end
    end
    in_valid_i <= 0;

    while (replies_owed != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
